@@ design/rcsfd_pkg.sv @@
`default_nettype none

package rcsfd_pkg;

    localparam int unsigned NUM_CHANNELS = 12;
    localparam int unsigned FRAME_BYTES  = 16;

    localparam int unsigned OPCODE_W  = 2;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CHAN_ID_W = 4;
    localparam int unsigned HEADER_W  = 16;
    localparam int unsigned VALUE_W   = 11;
    localparam int unsigned IDLE_W    = 8;
    localparam int unsigned PHASE_W   = 2;

    // buffer address, and a position that can also hold the frame length itself
    localparam int unsigned ADDR_W = $clog2(FRAME_BYTES);
    localparam int unsigned POS_W  = $clog2(FRAME_BYTES + 1);
    // store index, at least one bit even for a single channel
    localparam int unsigned CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [OPCODE_W-1:0] OP_BYTE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

    localparam logic [IDLE_W-1:0]  GAP_LIMIT_RESET = 8'd6;
    localparam logic [IDLE_W-1:0]  IDLE_MAX        = 8'hff;
    localparam logic [PHASE_W-1:0] PHASE_EVEN      = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_ODD       = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_BOTH      = 2'd3;

    // ids are compared one bit wider so that sixteen channels still fit
    localparam logic [CHAN_ID_W:0] CH_LIMIT = (CHAN_ID_W + 1)'(NUM_CHANNELS);

    typedef logic [VALUE_W-1:0] t_value;

endpackage

`default_nettype wire

@@ design/rcsfd_in_if.sv @@
`default_nettype none

interface rcsfd_in_if;
    logic                               valid;
    logic                               ready;
    logic [rcsfd_pkg::OPCODE_W-1:0]     opcode;
    logic [rcsfd_pkg::BYTE_W-1:0]       data_byte;
    logic [rcsfd_pkg::CHAN_ID_W-1:0]    channel_index;

    modport source (output valid, output opcode, output data_byte, output channel_index,
                    input ready);
    modport sink   (input valid, input opcode, input data_byte, input channel_index,
                    output ready);
endinterface

`default_nettype wire

@@ design/rcsfd_out_if.sv @@
`default_nettype none

interface rcsfd_out_if;
    logic                               valid;
    logic                               ready;
    logic                               frame_ready;
    logic [rcsfd_pkg::HEADER_W-1:0]     header_value;
    logic [rcsfd_pkg::VALUE_W-1:0]      read_value;

    modport source (output valid, output frame_ready, output header_value,
                    output read_value, input ready);
    modport sink   (input valid, input frame_ready, input header_value,
                    input read_value, output ready);
endinterface

`default_nettype wire

@@ design/rcsfd_cfg_if.sv @@
`default_nettype none

interface rcsfd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rcsfd_pkg::IDLE_W-1:0]       data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/rc_serial_frame_decoder_top.sv @@
`default_nettype none

// Serial frame decoder for a radio-receiver byte stream. Each input beat is a received
// byte, a millisecond tick or a channel read, and yields exactly one result beat carrying
// the frame-ready flag, the latest header word and the read value. Ticks, reads and bytes
// that do not finish a frame are handled directly and their result is registered. The byte
// that finishes a frame starts a decode sequencer that reads the frame buffer back one
// byte a cycle through a single read port and one id compare, and then waits for the
// output to be free before its result appears; no input is taken meanwhile. A result
// waiting on the output holds off the next input beat until it is taken; the two can
// pass in the same cycle. The gap limit register is written through its own channel,
// which is always ready.
module rc_serial_frame_decoder_top (
    input  wire             i_clk,
    input  wire             i_rst_n,
    rcsfd_cfg_if.sink       i_cfg,
    rcsfd_in_if.sink        i_item,
    rcsfd_out_if.source     o_result
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    localparam int unsigned POS_W  = rcsfd_pkg::POS_W;
    localparam int unsigned ADDR_W = rcsfd_pkg::ADDR_W;
    localparam int unsigned CH_W   = rcsfd_pkg::CH_W;
    localparam logic [POS_W-1:0] FRAME_LEN = POS_W'(rcsfd_pkg::FRAME_BYTES);

    logic [1:0]                         r_state;
    logic [rcsfd_pkg::IDLE_W-1:0]       r_gap_limit;
    logic [rcsfd_pkg::IDLE_W-1:0]       r_idle;
    logic [POS_W-1:0]                   r_pos;
    logic [POS_W-1:0]                   r_step;
    logic [rcsfd_pkg::PHASE_W-1:0]      r_phase;
    logic [rcsfd_pkg::HEADER_W-1:0]     r_header;
    logic [rcsfd_pkg::BYTE_W-1:0]       r_hi;
    logic [rcsfd_pkg::BYTE_W-1:0]       r_rd_data;
    logic [rcsfd_pkg::BYTE_W-1:0]       r_buf [rcsfd_pkg::FRAME_BYTES];
    rcsfd_pkg::t_value                  r_store [rcsfd_pkg::NUM_CHANNELS];

    logic                               r_out_valid;
    logic                               r_out_frame_ready;
    logic [rcsfd_pkg::HEADER_W-1:0]     r_out_header;
    rcsfd_pkg::t_value                  r_out_read;

    logic                               out_free;
    logic                               in_fire;
    logic                               byte_fire;
    logic [POS_W-1:0]                   pos_eff;
    logic [POS_W-1:0]                   n_pos;
    logic                               frame_end;
    logic [POS_W-1:0]                   data_idx;
    logic [rcsfd_pkg::CHAN_ID_W-1:0]    word_id;
    rcsfd_pkg::t_value                  read_val;

    assign i_cfg.ready  = 1'b1;
    assign out_free     = !r_out_valid || o_result.ready;
    assign i_item.ready = (r_state == ST_IDLE) && out_free;
    assign in_fire      = i_item.valid && i_item.ready;
    assign byte_fire    = in_fire && (i_item.opcode == rcsfd_pkg::OP_BYTE);

    // a long enough gap restarts the frame before this byte is stored
    assign pos_eff   = ((r_idle > r_gap_limit) || (r_pos >= FRAME_LEN)) ? '0 : r_pos;
    assign n_pos     = pos_eff + POS_W'(1);
    assign frame_end = (n_pos >= FRAME_LEN);

    // buffer byte that the registered read data belongs to
    assign data_idx = r_step - POS_W'(1);
    assign word_id  = r_hi[6:3];

    always_comb begin
        read_val = '0;
        if ((i_item.opcode == rcsfd_pkg::OP_READ) &&
            ({1'b0, i_item.channel_index} < rcsfd_pkg::CH_LIMIT)) begin
            read_val = r_store[i_item.channel_index[CH_W-1:0]];
        end
    end

    // frame buffer: written by byte beats, read back by the decode sequencer
    always_ff @(posedge i_clk) begin
        if (byte_fire) begin
            r_buf[pos_eff[ADDR_W-1:0]] <= i_item.data_byte;
        end
        r_rd_data <= r_buf[r_step[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit <= rcsfd_pkg::GAP_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_gap_limit <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idle      <= '0;
            r_pos       <= '0;
            r_step      <= '0;
            r_phase     <= '0;
            r_header    <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < rcsfd_pkg::NUM_CHANNELS; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            if (r_out_valid && o_result.ready && !in_fire) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_out_frame_ready <= 1'b0;
                        r_out_header      <= r_header;
                        r_out_read        <= read_val;
                        case (i_item.opcode)
                            rcsfd_pkg::OP_BYTE: begin
                                r_idle <= '0;
                                if (frame_end) begin
                                    r_pos       <= '0;
                                    r_step      <= '0;
                                    r_out_valid <= 1'b0;
                                    r_state     <= ST_DECODE;
                                end else begin
                                    r_pos       <= n_pos;
                                    r_out_valid <= 1'b1;
                                end
                            end
                            rcsfd_pkg::OP_TICK: begin
                                if (r_idle != rcsfd_pkg::IDLE_MAX) begin
                                    r_idle <= r_idle + 1'b1;
                                end
                                r_out_valid <= 1'b1;
                            end
                            rcsfd_pkg::OP_READ: begin
                                r_out_valid <= 1'b1;
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_DECODE: begin
                    // one buffer byte per cycle through the shared id compare and store port
                    if (r_step != '0) begin
                        if (data_idx == POS_W'(0)) begin
                            r_header[15:8] <= r_rd_data;
                        end else if (data_idx == POS_W'(1)) begin
                            r_header[7:0] <= r_rd_data;
                        end else if (!data_idx[0]) begin
                            r_hi <= r_rd_data;
                            if (data_idx == POS_W'(2)) begin
                                if (!r_rd_data[7]) begin
                                    r_phase <= rcsfd_pkg::PHASE_EVEN;
                                end else begin
                                    r_phase <= r_phase | rcsfd_pkg::PHASE_ODD;
                                end
                            end
                        end else if ({1'b0, word_id} < rcsfd_pkg::CH_LIMIT) begin
                            r_store[word_id[CH_W-1:0]] <= {r_hi[2:0], r_rd_data};
                        end
                    end
                    r_step <= r_step + POS_W'(1);
                    if (r_step == FRAME_LEN) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_frame_ready <= (r_phase == rcsfd_pkg::PHASE_BOTH);
                        r_out_header      <= r_header;
                        r_out_read        <= '0;
                        r_out_valid       <= 1'b1;
                        r_state           <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.frame_ready  = r_out_frame_ready;
    assign o_result.header_value = r_out_header;
    assign o_result.read_value   = r_out_read;

endmodule

`default_nettype wire
